[rtl/rvc_exp_pkg.sv]
// ----------------------------------------------------------------------------
// rvc_exp_pkg: shared types, opcodes and expansion function
// RV32C to RV32I expansion, written as pure functions over one compressed word.
// ----------------------------------------------------------------------------
package rvc_exp_pkg;

  localparam int unsigned CWordW = 16;
  localparam int unsigned XWordW = 32;

  localparam logic [6:0] OP_REG    = 7'b0110011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] F7_ALT    = 7'b0100000;
  localparam logic [6:0] F7_BASE   = 7'b0000000;
  localparam logic [4:0] REG_ZERO  = 5'b00000;
  localparam logic [4:0] REG_RA    = 5'b00001;
  localparam logic [4:0] REG_SP    = 5'b00010;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;

  // compressed funct3 codes
  localparam logic [2:0] CF3_0 = 3'd0;
  localparam logic [2:0] CF3_1 = 3'd1;
  localparam logic [2:0] CF3_2 = 3'd2;
  localparam logic [2:0] CF3_3 = 3'd3;
  localparam logic [2:0] CF3_4 = 3'd4;
  localparam logic [2:0] CF3_5 = 3'd5;
  localparam logic [2:0] CF3_6 = 3'd6;
  localparam logic [2:0] CF3_7 = 3'd7;

  // quadrant 1 arithmetic sub-codes, bits 11:10
  localparam logic [1:0] ALU_SRLI = 2'd0;
  localparam logic [1:0] ALU_SRAI = 2'd1;
  localparam logic [1:0] ALU_ANDI = 2'd2;
  localparam logic [1:0] ALU_REG  = 2'd3;

  // register-register sub-codes, bits 6:5
  localparam logic [1:0] RR_SUB = 2'd0;
  localparam logic [1:0] RR_XOR = 2'd1;
  localparam logic [1:0] RR_OR  = 2'd2;
  localparam logic [1:0] RR_AND = 2'd3;

  typedef struct packed {
    logic [XWordW-1:0] word;
    logic              illegal;
  } exp_result_t;

  function automatic logic [XWordW-1:0] enc_i(logic [11:0] imm, logic [4:0] rs1,
                                              logic [2:0] f3, logic [4:0] rd,
                                              logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [XWordW-1:0] enc_r(logic [6:0] f7, logic [4:0] rs2,
                                              logic [4:0] rs1, logic [2:0] f3,
                                              logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OP_REG};
  endfunction

  function automatic logic [XWordW-1:0] enc_s(logic [11:0] imm, logic [4:0] rs2,
                                              logic [4:0] rs1);
    return {imm[11:5], rs2, rs1, F3_WORD, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [XWordW-1:0] enc_b(logic [12:0] imm, logic [4:0] rs1,
                                              logic [2:0] f3);
    return {imm[12], imm[10:5], REG_ZERO, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
  endfunction

  function automatic logic [XWordW-1:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
  endfunction

  function automatic exp_result_t expand(logic [CWordW-1:0] c);
    exp_result_t r;
    logic        b12;
    logic [4:0]  rd;
    logic [4:0]  rs2;
    logic [4:0]  rdp;
    logic [4:0]  rs1p;
    logic [11:0] imm6;
    logic [11:0] memoff;
    logic [11:0] spn_imm;
    logic [11:0] sp16_imm;
    logic [20:0] jimm;
    logic [12:0] bimm;
    logic [2:0]  rr_f3;
    logic [6:0]  rr_f7;
    b12      = c[12];
    rd       = c[11:7];
    rs2      = c[6:2];
    rdp      = {2'b01, c[4:2]};
    rs1p     = {2'b01, c[9:7]};
    imm6     = {{7{c[12]}}, c[6:2]};
    memoff   = {5'b0, c[5], c[12:10], c[6], 2'b0};
    spn_imm  = {2'b0, c[10:7], c[12:11], c[5], c[6], 2'b0};
    sp16_imm = {{3{c[12]}}, c[4:3], c[5], c[2], c[6], 4'b0};
    jimm     = {{9{c[12]}}, c[12], c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3], 1'b0};
    bimm     = {{5{c[12]}}, c[6:5], c[2], c[11:10], c[4:3], 1'b0};
    r.word    = '0;
    r.illegal = 1'b1;
    case (c[6:5])
      RR_SUB:  begin rr_f3 = F3_ADD; rr_f7 = F7_ALT;  end
      RR_XOR:  begin rr_f3 = F3_XOR; rr_f7 = F7_BASE; end
      RR_OR:   begin rr_f3 = F3_OR;  rr_f7 = F7_BASE; end
      RR_AND:  begin rr_f3 = F3_AND; rr_f7 = F7_BASE; end
      default: begin rr_f3 = F3_AND; rr_f7 = F7_BASE; end
    endcase
    case (c[1:0])
      QUAD_0: begin
        case (c[15:13])
          CF3_0: begin
            if (c[12:5] != 8'd0) begin
              r.word    = enc_i(spn_imm, REG_SP, F3_ADD, rdp, OP_IMM);
              r.illegal = 1'b0;
            end
          end
          CF3_2: begin
            r.word    = enc_i(memoff, rs1p, F3_WORD, rdp, OP_LOAD);
            r.illegal = 1'b0;
          end
          CF3_6: begin
            r.word    = enc_s(memoff, rdp, rs1p);
            r.illegal = 1'b0;
          end
          default: ;
        endcase
      end
      QUAD_1: begin
        case (c[15:13])
          CF3_0: begin
            r.word    = enc_i(imm6, rd, F3_ADD, rd, OP_IMM);
            r.illegal = 1'b0;
          end
          CF3_1: begin
            r.word    = enc_j(jimm, REG_RA);
            r.illegal = 1'b0;
          end
          CF3_5: begin
            r.word    = enc_j(jimm, REG_ZERO);
            r.illegal = 1'b0;
          end
          CF3_2: begin
            r.word    = enc_i(imm6, REG_ZERO, F3_ADD, rd, OP_IMM);
            r.illegal = 1'b0;
          end
          CF3_3: begin
            if (rd == REG_SP) begin
              if ({b12, rs2} != 6'd0) begin
                r.word    = enc_i(sp16_imm, REG_SP, F3_ADD, REG_SP, OP_IMM);
                r.illegal = 1'b0;
              end
            end else if ({b12, rs2} != 6'd0) begin
              r.word    = {{15{c[12]}}, c[6:2], rd, OP_LUI};
              r.illegal = 1'b0;
            end
          end
          CF3_4: begin
            case (c[11:10])
              ALU_SRLI: begin
                if (!b12) begin
                  r.word    = enc_i({7'b0, rs2}, rs1p, F3_SR, rs1p, OP_IMM);
                  r.illegal = 1'b0;
                end
              end
              ALU_SRAI: begin
                if (!b12) begin
                  r.word    = enc_i({F7_ALT, rs2}, rs1p, F3_SR, rs1p, OP_IMM);
                  r.illegal = 1'b0;
                end
              end
              ALU_ANDI: begin
                r.word    = enc_i(imm6, rs1p, F3_AND, rs1p, OP_IMM);
                r.illegal = 1'b0;
              end
              ALU_REG: begin
                if (!b12) begin
                  r.word    = enc_r(rr_f7, rdp, rs1p, rr_f3, rs1p);
                  r.illegal = 1'b0;
                end
              end
              default: ;
            endcase
          end
          CF3_6: begin
            r.word    = enc_b(bimm, rs1p, F3_BEQ);
            r.illegal = 1'b0;
          end
          CF3_7: begin
            r.word    = enc_b(bimm, rs1p, F3_BNE);
            r.illegal = 1'b0;
          end
          default: ;
        endcase
      end
      QUAD_2: begin
        case (c[15:13])
          CF3_0: begin
            if (!b12) begin
              r.word    = enc_i({7'b0, rs2}, rd, F3_SLL, rd, OP_IMM);
              r.illegal = 1'b0;
            end
          end
          CF3_2: begin
            if (rd != REG_ZERO) begin
              r.word    = enc_i({4'b0, c[3:2], c[12], c[6:4], 2'b0}, REG_SP, F3_WORD, rd,
                                OP_LOAD);
              r.illegal = 1'b0;
            end
          end
          CF3_4: begin
            if (rs2 == REG_ZERO) begin
              if (rd != REG_ZERO) begin
                r.word    = enc_i(12'd0, rd, F3_ADD, b12 ? REG_RA : REG_ZERO, OP_JALR);
                r.illegal = 1'b0;
              end
            end else begin
              r.word    = enc_r(F7_BASE, rs2, b12 ? rd : REG_ZERO, F3_ADD, rd);
              r.illegal = 1'b0;
            end
          end
          CF3_6: begin
            r.word    = enc_s({4'b0, c[8:7], c[12:9], 2'b0}, rs2, REG_SP);
            r.illegal = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

endpackage

[rtl/rv32c_instruction_expander.sv]
// ----------------------------------------------------------------------------
// rv32c_instruction_expander: RV32C to RV32I instruction expansion
// An accepted word passes the input register and then the result register before out_valid.
// Throughput: one transaction per cycle; busy is never raised, the expansion
// logic sits between the input register and the result register.
// Reset clears the valid bits; no result appears until a new transaction.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module rv32c_instruction_expander (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [rvc_exp_pkg::CWordW-1:0]       in_compressed_word,
  output logic                                 out_valid,
  output logic [rvc_exp_pkg::XWordW-1:0]       out_expanded_word,
  output logic                                 out_illegal
);
  import rvc_exp_pkg::*;

  logic              in_valid_r;
  logic [CWordW-1:0] in_word_r;
  logic              out_valid_r;
  exp_result_t       res_nxt;
  exp_result_t       res_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_word_r <= in_compressed_word;
    end
    if (in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  always_comb begin
    res_nxt = expand(in_word_r);
  end

  assign out_valid         = out_valid_r;
  assign out_expanded_word = res_r.word;
  assign out_illegal       = res_r.illegal;

  // each accepted transaction gives one result, through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("result missing two cycles after transaction");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_valid_r))
    else $error("result without a transaction");

  a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_illegal) |-> (out_expanded_word == '0))
    else $error("illegal result carries a nonzero word");

  a_quad3_illegal: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && (in_word_r[1:0] == 2'b11)) |=> (out_valid && out_illegal))
    else $error("uncompressed word not flagged illegal");

endmodule
